// File: design/icv_pkg.sv
// Shared constants, types and register codes of the 3x3 convolution block.
package icv_pkg;

    localparam int PIX_BITS       = 8;
    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int W_BITS         = 11;
    localparam int H_BITS         = 13;
    localparam int COEF_BITS      = 18;
    localparam int COEF_FRAC_BITS = 12;
    localparam int ROW_COEF_BITS  = 3 * COEF_BITS;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = ROW_COEF_BITS;
    localparam int PROD_BITS      = COEF_BITS + PIX_BITS;
    localparam int RSUM_BITS      = PROD_BITS + 2;
    localparam int SUM_BITS       = PROD_BITS + 4;
    localparam int LINE_BITS      = 2 * PIX_BITS;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QP_BITS        = $clog2(QUEUE_DEPTH);
    localparam int QC_BITS        = $clog2(QUEUE_DEPTH + 1);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_TOP    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_MID    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT      = 3'd4;

    localparam logic [CFG_DATA_BITS-1:0] COEF_TOP_RESET    = '0;
    localparam logic [CFG_DATA_BITS-1:0] COEF_MID_RESET    = CFG_DATA_BITS'(4096);
    localparam logic [CFG_DATA_BITS-1:0] COEF_BOTTOM_RESET = '0;
    localparam logic [W_BITS-1:0]        WIDTH_RESET       = W_BITS'(640);
    localparam logic [H_BITS-1:0]        HEIGHT_RESET      = H_BITS'(480);

    // Request type codes.
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef struct packed {
        logic                     we;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
    } t_cfg_wr;

    // One classified request on its way to the arithmetic back end.
    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic [PIX_BITS-1:0] pix;
        logic                emit;
        logic                top_ok;
        logic                bot_ok;
        logic                left_ok;
        logic                right_ok;
        logic                last;
    } t_item;

    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef logic signed [RSUM_BITS-1:0] t_rsum;
    typedef logic signed [SUM_BITS-1:0]  t_sum;

endpackage

// File: design/icv_in_if.sv
// Request channel: valid/ready handshake carrying one pixel or drain request.
interface icv_in_if;
    import icv_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [PIX_BITS-1:0] pixel_in;

    modport source (output valid, output req_type, output pixel_in, input ready);
    modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

// File: design/icv_out_if.sv
// Result channel: valid/ready handshake carrying one filtered pixel.
interface icv_out_if;
    import icv_pkg::*;

    logic                valid;
    logic                ready;
    logic [PIX_BITS-1:0] pixel_out;
    logic                frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// File: design/image_convolution_3x3_zero_pad.sv
// Top level of the streaming 3x3 zero-padded image convolution.
//
//   channel   direction  handshake              payload
//   i_req     in         i_req.valid/ready      req_type, pixel_in
//   o_res     out        o_res.valid/ready      pixel_out, frame_last
//   i_cfg_*   in         i_cfg_we (no wait)     i_cfg_idx, i_cfg_data
//
// One request is taken per clock in steady state. The rate is set by the line
// memory, which has one read port and one write port, each used once per request.
// A result is offered on o_res after its triggering request has passed the queue,
// stages s1 to s4 and the output register. That request itself comes one image row
// plus one pixel after the centre pixel.
// Reset is synchronous and active low; it restores the register defaults
// and empties the queue and pipeline, with no memory clearing pass.
// A stalled result holds the back end only; the queue keeps taking requests
// until it fills, and then i_req.ready drops.
module image_convolution_3x3_zero_pad (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    icv_in_if.sink                             i_req,
    icv_out_if.source                          o_res,
    input  logic                               i_cfg_we,
    input  logic [icv_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [icv_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import icv_pkg::*;

    // Configuration writes are broadcast; each side decodes its own registers.
    t_cfg_wr cfg;
    logic    push;
    t_item   push_item;
    logic    q_full;
    logic    q_valid;
    t_item   q_item;
    logic    q_pop;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // The front end tracks the raster position, drops drain requests that
    // arrive inside the frame, and tags each kept request with its border
    // masks and whether it produces a result.
    icv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req       (i_req),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_item (push_item)
    );

    // The queue lets the front end keep accepting while the result side stalls.
    icv_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_item      (q_item)
    );

    // The back end keeps two rows in the line memory, shifts the 3x3 window,
    // multiplies, sums in two levels, then floors and saturates the result.
    icv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

// File: design/icv_front.sv
// Front end: raster position tracking, request classification and border masks.
module icv_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  icv_pkg::t_cfg_wr i_cfg,
    icv_in_if.sink           i_req,
    input  logic             i_q_full,
    output logic             o_push,
    output icv_pkg::t_item   o_push_item
);
    import icv_pkg::*;

    logic [W_BITS-1:0]   r_width;
    logic [H_BITS-1:0]   r_height;
    logic [H_BITS-1:0]   r_row;
    logic [COL_BITS-1:0] r_col;

    logic [W_BITS-1:0]   eff_w;
    logic [H_BITS-1:0]   eff_h;
    logic [H_BITS-1:0]   h_plus1;
    logic [W_BITS-1:0]   col_next;
    logic                accept;
    logic                full;
    logic                col_pos;
    logic                restart;
    t_item               item;

    always_comb begin
        if (r_width == '0) begin
            eff_w = W_BITS'(1);
        end else if (r_width > W_BITS'(MAX_WIDTH)) begin
            eff_w = W_BITS'(MAX_WIDTH);
        end else begin
            eff_w = r_width;
        end
        if (r_height == '0) begin
            eff_h = H_BITS'(1);
        end else if (r_height > H_BITS'(MAX_HEIGHT)) begin
            eff_h = H_BITS'(MAX_HEIGHT);
        end else begin
            eff_h = r_height;
        end
    end

    assign h_plus1  = eff_h + H_BITS'(1);
    assign col_next = W_BITS'(r_col) + W_BITS'(1);

    assign i_req.ready = !i_q_full;
    assign accept      = i_req.valid && i_req.ready;
    assign full        = (r_row >= eff_h);
    assign col_pos     = (r_col != '0);

    // The centre of the output window sits one row and one pixel behind the
    // incoming position; on column zero it is the last pixel two rows up.
    always_comb begin
        item.col      = r_col;
        item.pix      = full ? '0 : i_req.pixel_in;
        item.emit     = (r_row >= H_BITS'(2)) || ((r_row == H_BITS'(1)) && col_pos);
        item.top_ok   = col_pos ? (r_row >= H_BITS'(2)) : (r_row >= H_BITS'(3));
        item.bot_ok   = col_pos ? (r_row < eff_h) : (r_row <= eff_h);
        item.left_ok  = col_pos ? (r_col >= COL_BITS'(2)) : (eff_w >= W_BITS'(2));
        item.right_ok = col_pos;
        item.last     = !col_pos && (r_row == h_plus1);
    end

    // A drain request inside the frame carries no position and is dropped.
    assign o_push      = accept && !((i_req.req_type == REQ_DRAIN) && !full);
    assign o_push_item = item;
    assign restart     = i_cfg.we && ((i_cfg.idx == CFG_WIDTH) || (i_cfg.idx == CFG_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_row    <= '0;
            r_col    <= '0;
        end else begin
            if (i_cfg.we && (i_cfg.idx == CFG_WIDTH)) begin
                r_width <= i_cfg.data[W_BITS-1:0];
            end
            if (i_cfg.we && (i_cfg.idx == CFG_HEIGHT)) begin
                r_height <= i_cfg.data[H_BITS-1:0];
            end
            if (restart) begin
                r_row <= '0;
                r_col <= '0;
            end else if (o_push) begin
                if (item.last) begin
                    r_row <= '0;
                    r_col <= '0;
                end else if (col_next >= eff_w) begin
                    r_row <= r_row + H_BITS'(1);
                    r_col <= '0;
                end else begin
                    r_col <= col_next[COL_BITS-1:0];
                end
            end
        end
    end

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        W_BITS'(r_col) < eff_w)
        else $error("column counter left the image row");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= h_plus1)
        else $error("row counter ran past the drain rows");

endmodule

// File: design/icv_queue.sv
// Short request queue that decouples the front end from the back end.
module icv_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  icv_pkg::t_item i_push_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output icv_pkg::t_item o_item
);
    import icv_pkg::*;

    t_item              r_slot [QUEUE_DEPTH];
    logic [QP_BITS-1:0] r_wr;
    logic [QP_BITS-1:0] r_rd;
    logic [QC_BITS-1:0] r_count;

    assign o_full  = (r_count == QC_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QP_BITS'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QP_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QC_BITS'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QC_BITS'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("request popped from an empty queue");

endmodule

// File: design/icv_back.sv
// Back end: line memory, 3x3 window, multiply-accumulate and output register.
module icv_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  icv_pkg::t_cfg_wr i_cfg,
    input  logic             i_q_valid,
    input  icv_pkg::t_item   i_q_item,
    output logic             o_q_pop,
    icv_out_if.source        o_res
);
    import icv_pkg::*;

    logic [CFG_DATA_BITS-1:0] r_coef [3];

    logic [LINE_BITS-1:0] mem [MAX_WIDTH];
    logic [LINE_BITS-1:0] r_rd;
    logic                 r_byp;
    logic [LINE_BITS-1:0] r_byp_dat;

    logic  r_s1_valid;
    logic  r_s2_valid;
    logic  r_s3_valid;
    logic  r_s4_valid;
    t_item r_s1;
    t_item r_s2;
    logic  r_s3_emit;
    logic  r_s3_last;
    logic  r_s4_emit;
    logic  r_s4_last;

    logic [PIX_BITS-1:0] r_win [3][3];
    t_prod               r_prod [3][3];
    t_rsum               r_rsum [3];

    logic                r_out_valid;
    logic [PIX_BITS-1:0] r_out_pix;
    logic                r_out_last;

    logic                 en;
    logic [LINE_BITS-1:0] s1_line;
    logic [PIX_BITS-1:0]  s1_up2;
    logic [PIX_BITS-1:0]  s1_up1;
    logic [LINE_BITS-1:0] wr_line;
    logic                 row_ok [3];
    logic                 col_ok [3];
    logic [PIX_BITS-1:0]  win_px [3][3];
    t_prod                prod_c [3][3];
    t_rsum                rsum_c [3];
    t_sum                 total;
    logic [PIX_BITS-1:0]  pix_c;

    // The whole back end advances whenever the output register can take a result.
    assign en      = !r_out_valid || o_res.ready;
    assign o_q_pop = en && i_q_valid;

    // Each line entry holds the pixels of the two rows above, at one column.
    assign s1_line = r_byp ? r_byp_dat : r_rd;
    assign s1_up2  = s1_line[LINE_BITS-1:PIX_BITS];
    assign s1_up1  = s1_line[PIX_BITS-1:0];
    assign wr_line = {s1_up1, r_s1.pix};

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (i_q_valid) begin
                r_rd <= mem[i_q_item.col];
            end
            r_byp     <= r_s1_valid && (r_s1.col == i_q_item.col);
            r_byp_dat <= wr_line;
            if (r_s1_valid) begin
                mem[r_s1.col] <= wr_line;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= COEF_TOP_RESET;
            r_coef[1] <= COEF_MID_RESET;
            r_coef[2] <= COEF_BOTTOM_RESET;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_COEF_TOP:    r_coef[0] <= i_cfg.data;
                CFG_COEF_MID:    r_coef[1] <= i_cfg.data;
                CFG_COEF_BOTTOM: r_coef[2] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Pixels outside the image are forced to zero here, before the multiply.
    always_comb begin
        row_ok[0] = r_s2.top_ok;
        row_ok[1] = 1'b1;
        row_ok[2] = r_s2.bot_ok;
        col_ok[0] = r_s2.left_ok;
        col_ok[1] = 1'b1;
        col_ok[2] = r_s2.right_ok;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                win_px[i][j] = (row_ok[i] && col_ok[j]) ? r_win[i][j] : '0;
                prod_c[i][j] = t_prod'($signed(r_coef[i][j*COEF_BITS +: COEF_BITS]))
                             * t_prod'($signed({1'b0, win_px[i][j]}));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rsum_c[i] = t_rsum'(r_prod[i][0]) + t_rsum'(r_prod[i][1])
                      + t_rsum'(r_prod[i][2]);
        end
    end

    assign total = t_sum'(r_rsum[0]) + t_sum'(r_rsum[1]) + t_sum'(r_rsum[2]);

    always_comb begin
        if (total[SUM_BITS-1]) begin
            pix_c = '0;
        end else if (|total[SUM_BITS-2:COEF_FRAC_BITS+PIX_BITS]) begin
            pix_c = '1;
        end else begin
            pix_c = total[COEF_FRAC_BITS +: PIX_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_q_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid && r_s4_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= i_q_item;
            if (r_s1_valid) begin
                r_s2 <= r_s1;
                for (int i = 0; i < 3; i++) begin
                    r_win[i][0] <= r_win[i][1];
                    r_win[i][1] <= r_win[i][2];
                end
                r_win[0][2] <= s1_up2;
                r_win[1][2] <= s1_up1;
                r_win[2][2] <= r_s1.pix;
            end
            r_prod     <= prod_c;
            r_s3_emit  <= r_s2.emit;
            r_s3_last  <= r_s2.last;
            r_rsum     <= rsum_c;
            r_s4_emit  <= r_s3_emit;
            r_s4_last  <= r_s3_last;
            r_out_pix  <= pix_c;
            r_out_last <= r_s4_last;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.pixel_out  = r_out_pix;
    assign o_res.frame_last = r_out_last;

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s4_valid && r_s4_emit))
        else $error("result raised without an emitting request behind it");

endmodule

// File: dv/tb_image_convolution_3x3_zero_pad.sv
// Self-checking testbench for the streaming 3x3 zero-padded convolution block.
`timescale 1ns / 100ps

module tb_image_convolution_3x3_zero_pad;
    import icv_pkg::*;

    // The line ring spans two full rows plus the window overlap.
    localparam int RING_DEPTH    = 2 * MAX_WIDTH + 3;
    // Settling time for the queue and the back-end pipeline to empty; this is ample.
    localparam int SETTLE_CYCLES = 20;
    // Fill level of the random part, counted in image pixel requests.
    localparam int RANDOM_PIXELS = 300;

    // Kernel row shapes used when programming coefficients.
    typedef enum {TAPS_RANDOM, TAPS_SMALL, TAPS_BOX, TAPS_MAX, TAPS_MIN} t_taps_kind;

    typedef struct {
        logic [PIX_BITS-1:0] pix;
        logic                last;
    } t_conv_out;

    // Tracks the programmed registers and the stream position, keeps its own
    // copy of the recent pixels, and queues the filtered pixel that each
    // accepted request should produce.
    class conv_tracker;
        logic [ROW_COEF_BITS-1:0] coef_row [3];
        int                       width_reg;
        int                       height_reg;
        logic [PIX_BITS-1:0]      ring [RING_DEPTH];
        int                       row_idx;
        int                       col_idx;
        int                       ring_pos;
        t_conv_out                expected_px [$];
        int                       errors;

        function new();
            coef_row[0] = COEF_TOP_RESET;
            coef_row[1] = COEF_MID_RESET;
            coef_row[2] = COEF_BOTTOM_RESET;
            width_reg   = int'(WIDTH_RESET);
            height_reg  = int'(HEIGHT_RESET);
            foreach (ring[i]) ring[i] = '0;
            errors = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            row_idx  = 0;
            col_idx  = 0;
            ring_pos = 0;
        endfunction

        // Out-of-range sizes are clamped into 1..maximum.
        function int eff_w();
            if (width_reg < 1) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int eff_h();
            if (height_reg < 1) return 1;
            if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
            return height_reg;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_COEF_TOP:    coef_row[0] = data;
                CFG_COEF_MID:    coef_row[1] = data;
                CFG_COEF_BOTTOM: coef_row[2] = data;
                CFG_WIDTH: begin
                    width_reg = int'(data[W_BITS-1:0]);
                    restart_frame();
                end
                CFG_HEIGHT: begin
                    height_reg = int'(data[H_BITS-1:0]);
                    restart_frame();
                end
                default: ;
            endcase
        endfunction

        function longint tap(int r, int c);
            logic signed [COEF_BITS-1:0] t;
            t = coef_row[r][COEF_BITS*c +: COEF_BITS];
            return longint'(t);
        endfunction

        function void note_request(logic kind, logic [PIX_BITS-1:0] pix);
            int                  w, h, pos, k, r, c, rr, cc, span, idx;
            bit                  full, last;
            longint              sum, q;
            logic [PIX_BITS-1:0] px;
            t_conv_out           res;
            w    = eff_w();
            h    = eff_h();
            full = (row_idx >= h);
            pos  = row_idx * w + col_idx;
            last = 0;
            // A drain request before the frame is complete changes nothing.
            if (!full && kind == REQ_DRAIN) return;
            ring[ring_pos] = full ? '0 : pix;
            if (pos >= w + 1) begin
                k   = pos - w - 1;
                r   = k / w;
                c   = k % w;
                sum = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        rr = r + dr;
                        cc = c + dc;
                        px = '0;
                        if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
                            span = w + 1 - dr * w - dc;
                            idx  = (ring_pos + RING_DEPTH - span) % RING_DEPTH;
                            px   = ring[idx];
                        end
                        sum += tap(dr + 1, dc + 1) * longint'(px);
                    end
                end
                q = sum >>> COEF_FRAC_BITS;
                if (sum < 0) res.pix = '0;
                else if (q > 255) res.pix = 8'hFF;
                else res.pix = q[PIX_BITS-1:0];
                last     = (k == w * h - 1);
                res.last = last;
                expected_px.push_back(res);
            end
            ring_pos = (ring_pos + 1) % RING_DEPTH;
            col_idx++;
            if (col_idx >= w) begin
                col_idx = 0;
                row_idx++;
            end
            if (last) restart_frame();
        endfunction

        function void check_pixel(logic [PIX_BITS-1:0] pix, logic flag);
            t_conv_out want;
            if (expected_px.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: pixel_out %0d frame_last %0d",
                         $time, pix, flag);
                return;
            end
            want = expected_px.pop_front();
            if (pix !== want.pix) begin
                errors++;
                $display("%0t: pixel_out expected %0d, got %0d", $time, want.pix, pix);
            end
            if (flag !== want.last) begin
                errors++;
                $display("%0t: frame_last expected %0d, got %0d", $time, want.last, flag);
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    icv_in_if  req_if ();
    icv_out_if res_if ();

    conv_tracker tracker = new();

    // Receiver controls. rx_hold is loaded by the stimulus and counted down
    // by the receiver itself; no_idle turns off all gaps on both sides.
    int rx_hold   = 0;
    int rx_stall  = 0;
    bit no_idle   = 0;
    int random_px = 0;

    // Directed pattern of extreme pixels for the 3x3 frame.
    logic [PIX_BITS-1:0] edge_pattern [9] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                                              8'd0, 8'd255, 8'd255, 8'd255};

    image_convolution_3x3_zero_pad dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs. The slowest legal run stays far below.
    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Most gaps are zero or short; roughly one in sixteen is long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 31);
        if (r < 20) return 0;
        if (r < 30) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Pixels lean toward the two extremes now and then.
    function automatic logic [PIX_BITS-1:0] pick_px();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return PIX_BITS'($urandom_range(0, 255));
    endfunction

    function automatic t_taps_kind pick_taps();
        int r;
        r = $urandom_range(0, 11);
        if (r < 6) return TAPS_SMALL;
        if (r < 9) return TAPS_RANDOM;
        if (r == 9) return TAPS_BOX;
        if (r == 10) return TAPS_MAX;
        return TAPS_MIN;
    endfunction

    // Builds one kernel row; small taps keep most sums inside 0..255 so the
    // flooring path is exercised, not only the saturation.
    function automatic logic [ROW_COEF_BITS-1:0] coef_row_of(t_taps_kind kind);
        logic [ROW_COEF_BITS-1:0] row;
        int                       v;
        for (int c = 0; c < 3; c++) begin
            case (kind)
                TAPS_RANDOM: v = int'($urandom);
                TAPS_SMALL:  v = int'($urandom_range(0, 6144)) - 2048;
                TAPS_BOX:    v = 455;
                TAPS_MAX:    v = 'h1FFFF;
                default:     v = 'h20000;
            endcase
            row[COEF_BITS*c +: COEF_BITS] = COEF_BITS'(v);
        end
        return row;
    endfunction

    // Offers one request after a random gap and returns once it is accepted.
    // Valid stays high afterwards so a following request goes out back to back.
    task automatic send_req(logic kind, logic [PIX_BITS-1:0] pix);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= kind;
        req_if.pixel_in <= pix;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        tracker.note_request(kind, pix);
    endtask

    task automatic idle_req();
        req_if.valid <= 1'b0;
    endtask

    // Waits until every predicted result has come out, then lets the
    // pipeline settle so requests that produce nothing have also cleared.
    task automatic wait_idle();
        while (tracker.expected_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    // Programs all five registers; the size writes also restart the frame.
    task automatic configure(logic [CFG_DATA_BITS-1:0] top, logic [CFG_DATA_BITS-1:0] mid,
                             logic [CFG_DATA_BITS-1:0] bot, int wreg, int hreg);
        cfg_write(CFG_COEF_TOP, top);
        cfg_write(CFG_COEF_MID, mid);
        cfg_write(CFG_COEF_BOTTOM, bot);
        cfg_write(CFG_WIDTH, CFG_DATA_BITS'(wreg));
        cfg_write(CFG_HEIGHT, CFG_DATA_BITS'(hreg));
        cfg_we <= 1'b0;
    endtask

    // Streams one frame at the current size: the pixels, with the odd stray
    // drain request mixed in, then the width+1 drain requests, some of them
    // sent as pixel requests, which the block must treat as drains. A cut
    // frame stops early and is abandoned by the next size write.
    task automatic run_frame(bit cut, bit pause_mid);
        int w, h, n, stop;
        w    = tracker.eff_w();
        h    = tracker.eff_h();
        n    = w * h;
        stop = cut ? $urandom_range(1, n + w) : n + w + 1;
        for (int i = 0; i < stop; i++) begin
            if (pause_mid && i == n / 2) begin
                // The sender stops here until the block has emptied.
                idle_req();
                wait_idle();
            end
            if (i < n) begin
                if ($urandom_range(0, 15) == 0) send_req(REQ_DRAIN, pick_px());
                send_req(REQ_PIXEL, pick_px());
                random_px++;
            end else begin
                send_req(($urandom_range(0, 3) == 0) ? REQ_PIXEL : REQ_DRAIN, pick_px());
            end
        end
        // A drain right after the frame end falls into the new frame and is ignored.
        if (!cut && $urandom_range(0, 3) == 0) send_req(REQ_DRAIN, pick_px());
    endtask

    task automatic run_phase(int wreg, int hreg, int frames, bit cut_last, bit pause_mid);
        configure(coef_row_of(pick_taps()), coef_row_of(pick_taps()),
                  coef_row_of(pick_taps()), wreg, hreg);
        for (int f = 0; f < frames; f++)
            run_frame(cut_last && f == frames - 1, pause_mid && f == 0);
        idle_req();
        wait_idle();
    endtask

    // The receiver samples the result channel at each rising edge and then
    // decides whether it takes the next result. A long hold takes priority
    // over the usual short stalls.
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
                tracker.check_pixel(res_if.pixel_out, res_if.frame_last);
            if (rx_hold > 0) begin
                res_if.ready <= 1'b0;
                rx_hold--;
            end else if (no_idle) begin
                res_if.ready <= 1'b1;
            end else if (rx_stall > 0) begin
                res_if.ready <= 1'b0;
                rx_stall--;
            end else begin
                res_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) rx_stall = pick_gap();
            end
        end
    end

    initial begin
        int phase_no;
        int w;
        int h;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_COEF_TOP;
        cfg_data        <= '0;
        req_if.valid    <= 1'b0;
        req_if.req_type <= REQ_PIXEL;
        req_if.pixel_in <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: a 640 wide frame with the left-tap kernel. A little
        // over one row is enough to see results; the size writes below
        // abandon the rest of the frame.
        repeat (660) send_req(REQ_PIXEL, pick_px());
        idle_req();
        wait_idle();

        // Directed: a 3x3 frame of extreme pixels through a box filter, with a
        // stray drain before and inside the frame and a pixel request in the
        // drain stage.
        configure(coef_row_of(TAPS_BOX), coef_row_of(TAPS_BOX), coef_row_of(TAPS_BOX), 3, 3);
        send_req(REQ_DRAIN, 8'd255);
        for (int i = 0; i < 9; i++) begin
            send_req(REQ_PIXEL, edge_pattern[i]);
            if (i == 3) send_req(REQ_DRAIN, 8'd0);
        end
        send_req(REQ_DRAIN, 8'd0);
        send_req(REQ_PIXEL, 8'd255);
        send_req(REQ_DRAIN, 8'd255);
        send_req(REQ_DRAIN, 8'd0);
        idle_req();
        wait_idle();

        // Zero sizes count as one: a single-pixel frame with the largest taps,
        // followed by an ignored drain at the start of the next frame.
        configure(coef_row_of(TAPS_MAX), coef_row_of(TAPS_MAX), coef_row_of(TAPS_MAX), 0, 0);
        send_req(REQ_PIXEL, 8'd200);
        send_req(REQ_PIXEL, 8'd7);
        send_req(REQ_DRAIN, 8'd0);
        send_req(REQ_DRAIN, 8'd1);
        idle_req();
        wait_idle();

        // The most negative taps must floor every result to zero.
        configure(coef_row_of(TAPS_MIN), coef_row_of(TAPS_MIN), coef_row_of(TAPS_MIN), 2, 1);
        send_req(REQ_PIXEL, 8'd255);
        send_req(REQ_PIXEL, 8'd255);
        repeat (3) send_req(REQ_DRAIN, 8'd0);
        idle_req();
        wait_idle();

        // Random frames, mostly small. The first phase starts with a long
        // receiver hold so the block fills up and stalls its request input;
        // the second pauses the sender halfway until all results are out.
        phase_no = 0;
        while (random_px < RANDOM_PIXELS) begin
            if (phase_no == 0) begin
                w = 8;
                h = 8;
                no_idle = 0;
                rx_hold = 300;
            end else begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                h = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
                no_idle = ($urandom_range(0, 5) == 0);
            end
            run_phase(w, h, (phase_no == 0) ? 2 : $urandom_range(1, 3),
                      phase_no != 0 && $urandom_range(0, 4) == 0,
                      phase_no == 1 || $urandom_range(0, 9) == 0);
            phase_no++;
        end
        no_idle = 0;

        idle_req();
        wait_idle();
        if (tracker.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/icv_pkg.sv
design/icv_in_if.sv
design/icv_out_if.sv
design/icv_front.sv
design/icv_queue.sv
design/icv_back.sv
design/image_convolution_3x3_zero_pad.sv
dv/tb_image_convolution_3x3_zero_pad.sv
